[hdl/mm4x4_pkg.sv]
// Shared widths, command codes and word layouts for the 4x4 matrix multiplier.
// Used by matrix_multiply_4x4 and its port checker; depends on nothing else.

package mm4x4_pkg;

   localparam int DIM       = 4;
   localparam int IDX_W     = $clog2(DIM);
   localparam int ADDR_W    = $clog2(DIM * DIM);
   localparam int PHASE_W   = $clog2(DIM + 2);

   localparam int CMD_W     = 2;
   localparam int ROW_W     = 2;
   localparam int COL_W     = 2;
   localparam int ELEM_W    = 16;
   localparam int PROD_W    = 2 * ELEM_W;
   localparam int ACC_W     = 34;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;

   localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

   typedef struct packed {
      logic [REQ_DATA_W-ROW_W-COL_W-ELEM_W-1:0] pad;
      logic [ELEM_W-1:0]                        element_value;
      logic [COL_W-1:0]                         col;
      logic [ROW_W-1:0]                         row;
   } req_data_type;

   typedef struct packed {
      logic [RSP_DATA_W-ROW_W-COL_W-ACC_W-1:0] pad;
      logic [ACC_W-1:0]                        product_value;
      logic [COL_W-1:0]                        out_col;
      logic [ROW_W-1:0]                        out_row;
   } rsp_data_type;

endpackage

[hdl/matrix_multiply_4x4.sv]
// Top level of the 4x4 matrix multiplier: element stores, shared multiply-accumulate
// unit and its sequencer, and the result output register. Depends on mm4x4_pkg.
//
// Usage:
//   The req channel takes one word per item. tuser carries the command: load an
//   element of A, load an element of B, or compute. Loads are taken while the block
//   is idle and stream at one word per cycle while it is idle. A compute word drops req_tready and
//   the block walks the 16 product entries in row-major order on the rsp channel,
//   rsp_tlast marking the final entry.
//   Each entry runs its 4 terms through one 16x16 multiplier and a 34-bit
//   accumulator: each term is read from the stores into the store read register,
//   multiplied into the multiply register and summed; the finished entry is then
//   handed to the output register, and only then does the next entry start.
//   req_tready rises again in the cycle after the last entry enters the output
//   register; that entry may still wait there while new loads are taken.
//   A stalled receiver holds the current entry in the output register and the
//   sequencer waits before loading the next one; nothing is dropped.
//   Reset clears the sequencer and the output valid flag. Store contents are
//   not cleared: read an element only after writing it.

module matrix_multiply_4x4 (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: row [1:0], col [3:2], element_value [19:4], zero [23:20]
   input  logic [mm4x4_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser: command [1:0]
   input  logic [mm4x4_pkg::CMD_W-1:0]         req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: out_row [1:0], out_col [3:2], product_value [37:4], zero [39:38]
   output logic [mm4x4_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tlast
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MAC  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   localparam int IDX_W   = mm4x4_pkg::IDX_W;
   localparam int ADDR_W  = mm4x4_pkg::ADDR_W;
   localparam int PHASE_W = mm4x4_pkg::PHASE_W;
   localparam int ELEM_W  = mm4x4_pkg::ELEM_W;
   localparam int PROD_W  = mm4x4_pkg::PROD_W;
   localparam int ACC_W   = mm4x4_pkg::ACC_W;

   logic [1:0]         state_ff, state_in;
   logic [IDX_W-1:0]   r_ff, r_in;
   logic [IDX_W-1:0]   c_ff, c_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;

   logic [ELEM_W-1:0]  a_mem [mm4x4_pkg::DIM*mm4x4_pkg::DIM];
   logic [ELEM_W-1:0]  b_mem [mm4x4_pkg::DIM*mm4x4_pkg::DIM];
   logic [ELEM_W-1:0]  a_rd_ff;
   logic [ELEM_W-1:0]  b_rd_ff;
   logic signed [PROD_W-1:0] prod_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   mm4x4_pkg::rsp_data_type        rsp_data_ff, rsp_data_in;
   logic                           rsp_last_ff, rsp_last_in;

   mm4x4_pkg::req_data_type req_data;
   logic                    req_accept;
   logic                    in_range;
   logic                    we_a;
   logic                    we_b;
   logic [ADDR_W-1:0]       wr_addr;
   logic [IDX_W-1:0]        k_idx;
   logic [ADDR_W-1:0]       a_addr;
   logic [ADDR_W-1:0]       b_addr;
   logic [ACC_W-1:0]        prod_ext;
   logic                    out_free;

   assign req_data   = req_tdata;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign in_range   = (req_data.row < mm4x4_pkg::DIM) && (req_data.col < mm4x4_pkg::DIM);
   assign we_a       = req_accept && in_range && (req_tuser == mm4x4_pkg::CMD_LOAD_A);
   assign we_b       = req_accept && in_range && (req_tuser == mm4x4_pkg::CMD_LOAD_B);
   assign wr_addr    = ADDR_W'(req_data.row) * ADDR_W'(mm4x4_pkg::DIM) + ADDR_W'(req_data.col);

   assign k_idx    = phase_ff[IDX_W-1:0];
   assign a_addr   = ADDR_W'(r_ff) * ADDR_W'(mm4x4_pkg::DIM) + ADDR_W'(k_idx);
   assign b_addr   = ADDR_W'(k_idx) * ADDR_W'(mm4x4_pkg::DIM) + ADDR_W'(c_ff);
   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (we_a) begin
         a_mem[wr_addr] <= req_data.element_value;
      end
      if (we_b) begin
         b_mem[wr_addr] <= req_data.element_value;
      end
      a_rd_ff <= a_mem[a_addr];
      b_rd_ff <= b_mem[b_addr];
   end

   always_ff @(posedge clock) begin
      prod_ff <= $signed(a_rd_ff) * $signed(b_rd_ff);
   end

   always_comb begin
      state_in     = state_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_tuser == mm4x4_pkg::CMD_COMPUTE)) begin
               r_in     = '0;
               c_in     = '0;
               phase_in = '0;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            phase_in = phase_ff + PHASE_W'(1);
            if (phase_ff == PHASE_W'(2)) begin
               acc_in = prod_ext;
            end else if (phase_ff > PHASE_W'(2)) begin
               acc_in = acc_ff + prod_ext;
            end
            if (phase_ff == PHASE_W'(mm4x4_pkg::DIM + 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.pad           = '0;
               rsp_data_in.out_row       = mm4x4_pkg::ROW_W'(r_ff);
               rsp_data_in.out_col       = mm4x4_pkg::COL_W'(c_ff);
               rsp_data_in.product_value = acc_ff;
               rsp_last_in               = (r_ff == IDX_W'(mm4x4_pkg::DIM - 1)) &&
                                           (c_ff == IDX_W'(mm4x4_pkg::DIM - 1));
               phase_in                  = '0;
               state_in                  = ST_MAC;
               if (c_ff == IDX_W'(mm4x4_pkg::DIM - 1)) begin
                  c_in = '0;
                  if (r_ff == IDX_W'(mm4x4_pkg::DIM - 1)) begin
                     state_in = ST_IDLE;
                  end else begin
                     r_in = r_ff + IDX_W'(1);
                  end
               end else begin
                  c_in = c_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff        <= r_in;
      c_ff        <= c_in;
      phase_ff    <= phase_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[hdl/mm4x4_checker.sv]
// Port-level checker for matrix_multiply_4x4 and the bind that attaches it.
// Depends on mm4x4_pkg and the top level's ports.

module mm4x4_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [mm4x4_pkg::REQ_DATA_W-1:0]    req_tdata,
   input logic [mm4x4_pkg::CMD_W-1:0]         req_tuser,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [mm4x4_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input logic                                rsp_tlast
);

   property p_req_hold;
      @(posedge clock) disable iff (reset)
         (req_tvalid && !req_tready) |=>
            (req_tvalid && $stable(req_tdata) && $stable(req_tuser));
   endproperty
   a_req_hold: assert property (p_req_hold) else $error("req word changed while waiting");

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast));
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("rsp word changed while stalled");

   property p_reset_clears;
      @(posedge clock) reset |=> (!rsp_tvalid && req_tready);
   endproperty
   a_reset_clears: assert property (p_reset_clears) else $error("reset left block busy");

   property p_compute_busy;
      @(posedge clock) disable iff (reset)
         (req_tvalid && req_tready && (req_tuser == mm4x4_pkg::CMD_COMPUTE)) |=> !req_tready;
   endproperty
   a_compute_busy: assert property (p_compute_busy) else $error("ready during compute");

   property p_no_spurious_rsp;
      @(posedge clock) disable iff (reset)
         (req_tready && !rsp_tvalid) |=> !rsp_tvalid;
   endproperty
   a_no_spurious_rsp: assert property (p_no_spurious_rsp) else $error("rsp word while idle");

endmodule

bind matrix_multiply_4x4 mm4x4_checker u_mm4x4_checker (.*);

[test/tb_matrix_multiply_4x4.sv]
// Self-checking testbench for matrix_multiply_4x4: streams element loads and compute words,
// predicts every product entry and compares each rsp word field by field.
// Depends on mm4x4_pkg and matrix_multiply_4x4.

module tb_matrix_multiply_4x4;

   localparam int DIM        = mm4x4_pkg::DIM;
   localparam int CMD_W      = mm4x4_pkg::CMD_W;
   localparam int ROW_W      = mm4x4_pkg::ROW_W;
   localparam int COL_W      = mm4x4_pkg::COL_W;
   localparam int ELEM_W     = mm4x4_pkg::ELEM_W;
   localparam int ACC_W      = mm4x4_pkg::ACC_W;
   localparam int REQ_DATA_W = mm4x4_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W = mm4x4_pkg::RSP_DATA_W;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int HOLD_CYCLES  = 250;
   localparam int TAIL_CYCLES  = 40;
   localparam int IDLE_PERCENT = 33;

   typedef struct {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [ACC_W-1:0] value;
      logic             last;
   } product_entry_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0]      req_tuser = CMD_UNUSED;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   logic [ELEM_W-1:0] a_elems [0:DIM*DIM-1];
   logic [ELEM_W-1:0] b_elems [0:DIM*DIM-1];
   product_entry_type pending_products [$];
   int                error_count = 0;
   bit                sender_gaps = 1'b1;
   bit                receiver_gaps = 1'b1;
   int                stall_req = 0;
   int                stall_seen = 0;
   int                hold_left = 0;

   matrix_multiply_4x4 i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // update the element stores and queue the 16 entries of a compute
   task automatic track_word(input logic [CMD_W-1:0] cmd, input logic [ROW_W-1:0] r,
                             input logic [COL_W-1:0] c, input logic [ELEM_W-1:0] v);
      product_entry_type e;
      longint sum;
      int i, j, k;
      case (cmd)
         mm4x4_pkg::CMD_LOAD_A: a_elems[{r, c}] = v;
         mm4x4_pkg::CMD_LOAD_B: b_elems[{r, c}] = v;
         mm4x4_pkg::CMD_COMPUTE: begin
            for (i = 0; i < DIM; i++) begin
               for (j = 0; j < DIM; j++) begin
                  sum = 0;
                  for (k = 0; k < DIM; k++)
                     sum += longint'($signed(a_elems[i*DIM+k])) *
                            longint'($signed(b_elems[k*DIM+j]));
                  e.row   = ROW_W'(i);
                  e.col   = COL_W'(j);
                  e.value = ACC_W'(sum);
                  e.last  = (i == DIM-1) && (j == DIM-1);
                  pending_products.push_back(e);
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [ROW_W-1:0] r,
                            input logic [COL_W-1:0] c, input logic [ELEM_W-1:0] v);
      mm4x4_pkg::req_data_type w;
      w = '0;
      w.row = r;
      w.col = c;
      w.element_value = v;
      if (sender_gaps) begin
         while ($urandom_range(99) < IDLE_PERCENT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= w;
      do @(posedge clock); while (!req_tready);
      track_word(cmd, r, c, v);
   endtask

   task automatic wait_drained();
      while (pending_products.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [ELEM_W-1:0] pick_value();
      case ($urandom_range(9))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'h0000;
         3:       return 16'hffff;
         4:       return ELEM_W'($urandom_range(511) - 256);
         default: return ELEM_W'($urandom);
      endcase
   endfunction

   task automatic send_random_load();
      send_word($urandom_range(1) ? mm4x4_pkg::CMD_LOAD_B : mm4x4_pkg::CMD_LOAD_A,
                ROW_W'($urandom_range(3)), COL_W'($urandom_range(3)), pick_value());
   endtask

   // fill both stores with extremes so sums reach both ends of the range
   task automatic test_extremes();
      int r, c;
      for (r = 0; r < DIM; r++) begin
         for (c = 0; c < DIM; c++) begin
            send_word(mm4x4_pkg::CMD_LOAD_A, ROW_W'(r), COL_W'(c),
                      (r == 0) ? 16'h8000 : (r == 1) ? 16'h7fff : (r == 2) ? 16'h0000 :
                      ((c[0]) ? 16'h8000 : 16'h7fff));
         end
      end
      for (r = 0; r < DIM; r++) begin
         for (c = 0; c < DIM; c++) begin
            send_word(mm4x4_pkg::CMD_LOAD_B, ROW_W'(r), COL_W'(c),
                      (c == 0) ? 16'h8000 : (c == 1) ? 16'h7fff : (c == 2) ? 16'hffff :
                      ((r[0]) ? 16'h0001 : 16'h8000));
         end
      end
      send_word(mm4x4_pkg::CMD_COMPUTE, 2'd3, 2'd3, 16'hffff);
      send_word(CMD_UNUSED, 2'd0, 2'd0, 16'h1234);
      send_word(CMD_UNUSED, 2'd3, 2'd3, 16'hffff);
      send_word(mm4x4_pkg::CMD_COMPUTE, 2'd0, 2'd0, 16'h0000);
   endtask

   task automatic test_back_to_back();
      int n;
      sender_gaps = 1'b0;
      receiver_gaps <= 1'b0;
      for (n = 0; n < 18; n++)
         send_random_load();
      send_word(mm4x4_pkg::CMD_COMPUTE, 2'd1, 2'd2, 16'h5a5a);
      send_word(mm4x4_pkg::CMD_COMPUTE, 2'd2, 2'd1, 16'ha5a5);
      send_random_load();
      send_word(mm4x4_pkg::CMD_COMPUTE, 2'd0, 2'd0, 16'h0000);
      sender_gaps = 1'b1;
      receiver_gaps <= 1'b1;
   endtask

   task automatic test_receiver_hold();
      int n;
      stall_req <= stall_req + 1;
      send_word(mm4x4_pkg::CMD_COMPUTE, 2'd0, 2'd0, 16'h0000);
      for (n = 0; n < 20; n++)
         send_random_load();
      send_word(mm4x4_pkg::CMD_COMPUTE, 2'd3, 2'd0, 16'h0000);
   endtask

   task automatic test_drain();
      int n;
      send_word(mm4x4_pkg::CMD_COMPUTE, 2'd0, 2'd0, 16'h0000);
      req_tvalid <= 1'b0;
      wait_drained();
      for (n = 0; n < 8; n++)
         send_random_load();
      send_word(mm4x4_pkg::CMD_COMPUTE, 2'd0, 2'd0, 16'h0000);
   endtask

   task automatic test_random(input int count);
      int n;
      int pick;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 8)
            send_word(mm4x4_pkg::CMD_COMPUTE, ROW_W'($urandom), COL_W'($urandom),
                      ELEM_W'($urandom));
         else if (pick < 11)
            send_word(CMD_UNUSED, ROW_W'($urandom), COL_W'($urandom), ELEM_W'($urandom));
         else
            send_random_load();
      end
   endtask

   // drive rsp_tready: long hold on request, else random or steady
   always @(posedge clock) begin
      if (stall_req != stall_seen) begin
         stall_seen <= stall_req;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (receiver_gaps) begin
         rsp_tready <= ($urandom_range(99) >= IDLE_PERCENT);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      mm4x4_pkg::rsp_data_type w;
      product_entry_type       e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         w = rsp_tdata;
         if (pending_products.size() == 0) begin
            $display("%0t: unexpected word, actual row %0d col %0d value %0d last %0b",
                     $time, w.out_row, w.out_col, $signed(w.product_value), rsp_tlast);
            error_count++;
         end else begin
            e = pending_products.pop_front();
            if (w.out_row !== e.row) begin
               $display("%0t: out_row expected %0d actual %0d", $time, e.row, w.out_row);
               error_count++;
            end
            if (w.out_col !== e.col) begin
               $display("%0t: out_col expected %0d actual %0d", $time, e.col, w.out_col);
               error_count++;
            end
            if (w.product_value !== e.value) begin
               $display("%0t: product_value expected %0d actual %0d", $time,
                        $signed(e.value), $signed(w.product_value));
               error_count++;
            end
            if (rsp_tlast !== e.last) begin
               $display("%0t: tlast expected %0b actual %0b", $time, e.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_back_to_back();
      test_receiver_hold();
      test_drain();
      test_random(220);
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_products.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

[sim.f]
hdl/mm4x4_pkg.sv
hdl/matrix_multiply_4x4.sv
hdl/mm4x4_checker.sv
test/tb_matrix_multiply_4x4.sv
